FILE: sv/smes_pkg.sv
// Shared types and codes for the sparse matrix entry store.
package smes_pkg;

	// Command codes on the request channel
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	// Result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_RANGE    = 3'd1;
	localparam logic [2:0] ST_ABSENT   = 3'd2;
	localparam logic [2:0] ST_OCCUPIED = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	// Configuration register indexes
	localparam int REG_INDEX_BITS = 2;
	localparam logic [REG_INDEX_BITS-1:0] REG_ROW_COUNT = 2'd0;
	localparam logic [REG_INDEX_BITS-1:0] REG_COL_COUNT = 2'd1;

	// Depth of the request queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Classified operation handed from front to back
	typedef enum logic [2:0] {
		OP_INSERT,
		OP_REMOVE,
		OP_READ,
		OP_NOP,
		OP_RANGE
	} op_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// Handshake between the request queue and its consumer
	typedef struct packed {
		logic empty;
		logic pop;
	} queue_ctl_t;

endpackage

FILE: sv/smes_front.sv
// Front end: dimension registers and request classification.
module smes_front #(
	parameter int INDEX_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    write_en,
	input  logic [smes_pkg::REG_INDEX_BITS-1:0]     reg_index,
	input  logic [INDEX_BITS-1:0]                   write_data,
	input  logic [1:0]                              command,
	input  logic [INDEX_BITS-1:0]                   row,
	input  logic [INDEX_BITS-1:0]                   col,
	output smes_pkg::op_t                           op
);

	logic [INDEX_BITS-1:0] row_count_q;
	logic [INDEX_BITS-1:0] col_count_q;
	logic                  out_of_range;

	// Hold the matrix dimensions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= INDEX_BITS'(1);
			col_count_q <= INDEX_BITS'(1);
		end else if (write_en) begin
			if (reg_index == smes_pkg::REG_ROW_COUNT) begin
				row_count_q <= write_data;
			end
			if (reg_index == smes_pkg::REG_COL_COUNT) begin
				col_count_q <= write_data;
			end
		end
	end

	// Check the 1-based indices against the dimensions
	assign out_of_range = (row == '0) || (row > row_count_q) ||
		(col == '0) || (col > col_count_q);

	// Classify the request; the unused command code wins over the range check
	always_comb begin
		case (command)
			smes_pkg::CMD_INSERT: op = smes_pkg::OP_INSERT;
			smes_pkg::CMD_REMOVE: op = smes_pkg::OP_REMOVE;
			smes_pkg::CMD_READ:   op = smes_pkg::OP_READ;
			default:              op = smes_pkg::OP_NOP;
		endcase
		if (op != smes_pkg::OP_NOP && out_of_range) begin
			op = smes_pkg::OP_RANGE;
		end
	end

endmodule

FILE: sv/smes_queue.sv
// Short request queue between the front end and the table scanner.
module smes_queue #(
	parameter int WIDTH = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [WIDTH-1:0]     push_data,
	output logic                 full,
	input  smes_pkg::queue_ctl_t ctl_in,
	output logic                 empty,
	output logic [WIDTH-1:0]     pop_data
);

	localparam int Depth = smes_pkg::QUEUE_DEPTH;
	localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntBits = $clog2(Depth + 1);

	logic [WIDTH-1:0]   slot_q [Depth];
	logic [PtrBits-1:0] wr_ptr_q;
	logic [PtrBits-1:0] rd_ptr_q;
	logic [CntBits-1:0] count_q;
	logic               pop;

	assign pop      = ctl_in.pop;
	assign full     = (count_q == CntBits'(Depth));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	// Store pushed requests
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("request pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("request popped from an empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntBits'(Depth))
		else $error("queue occupancy beyond its depth");
`endif

endmodule

FILE: sv/smes_back.sv
// Back end: scans the entry table one slot per cycle and applies the request.
module smes_back #(
	parameter int ENTRY_COUNT = 64,
	parameter int INDEX_BITS  = 16,
	parameter int VALUE_BITS  = 32,
	parameter int QW          = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  empty,
	input  logic [QW-1:0]         pop_data,
	output smes_pkg::queue_ctl_t  ctl_out,
	output logic                  done,
	output logic [2:0]            status,
	output logic signed [31:0]    read_value
);

	localparam int AW   = $clog2(ENTRY_COUNT);
	localparam int OPW  = $bits(smes_pkg::op_t);
	localparam int WW   = 2 * INDEX_BITS + VALUE_BITS;

	smes_pkg::state_t state_q, state_d;

	// Current request
	smes_pkg::op_t         cur_op_q;
	logic [INDEX_BITS-1:0] cur_row_q;
	logic [INDEX_BITS-1:0] cur_col_q;
	logic [VALUE_BITS-1:0] cur_val_q;

	// Entry table
	logic [WW-1:0]          mem [ENTRY_COUNT];
	logic [ENTRY_COUNT-1:0] valid_q;

	// Scan pipeline
	logic [AW-1:0]         addr_q;
	logic                  live_s1;
	logic                  valid_s1;
	logic [WW-1:0]         word_s1;
	logic [AW-1:0]         idx_s1;

	// Scan results
	logic                  hit_q;
	logic [AW-1:0]         hit_idx_q;
	logic [VALUE_BITS-1:0] hit_val_q;
	logic                  free_q;
	logic [AW-1:0]         free_idx_q;

	// Result registers
	logic                  done_q;
	logic [2:0]            status_q;
	logic signed [31:0]    read_value_q;

	// Sequencer controls
	logic                  pop;
	logic                  issue;
	logic                  finish;
	logic                  last_addr;
	smes_pkg::op_t         in_op;
	logic                  needs_scan;

	logic [INDEX_BITS-1:0] s1_row;
	logic [INDEX_BITS-1:0] s1_col;
	logic                  s1_match;
	logic                  do_write;
	logic                  do_clear;
	logic [2:0]            status_d;
	logic signed [31:0]    value_d;

	assign in_op      = smes_pkg::op_t'(pop_data[QW-1 -: OPW]);
	assign needs_scan = (in_op == smes_pkg::OP_INSERT) || (in_op == smes_pkg::OP_REMOVE) ||
		(in_op == smes_pkg::OP_READ);
	assign last_addr  = (addr_q == AW'(ENTRY_COUNT - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			smes_pkg::ST_IDLE: begin
				if (!empty) begin
					state_d = needs_scan ? smes_pkg::ST_SCAN : smes_pkg::ST_FINISH;
				end
			end
			smes_pkg::ST_SCAN: begin
				if (last_addr) begin
					state_d = smes_pkg::ST_DRAIN;
				end
			end
			smes_pkg::ST_DRAIN:  state_d = smes_pkg::ST_FINISH;
			smes_pkg::ST_FINISH: state_d = smes_pkg::ST_IDLE;
			default:             state_d = smes_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		pop    = 1'b0;
		issue  = 1'b0;
		finish = 1'b0;
		case (state_q)
			smes_pkg::ST_IDLE:   pop    = !empty;
			smes_pkg::ST_SCAN:   issue  = 1'b1;
			smes_pkg::ST_FINISH: finish = 1'b1;
			default: begin
			end
		endcase
	end

	assign ctl_out.pop   = pop;
	assign ctl_out.empty = empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smes_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Latch the request taken from the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_op_q <= smes_pkg::OP_NOP;
		end else if (pop) begin
			cur_op_q <= in_op;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_row_q <= pop_data[QW-OPW-1 -: INDEX_BITS];
			cur_col_q <= pop_data[QW-OPW-INDEX_BITS-1 -: INDEX_BITS];
			cur_val_q <= pop_data[VALUE_BITS-1:0];
		end
	end

	// Advance the scan address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			live_s1 <= 1'b0;
		end else begin
			live_s1 <= issue;
			if (pop) begin
				addr_q <= '0;
			end else if (issue && !last_addr) begin
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	// Finish decisions
	assign do_write = finish && (cur_op_q == smes_pkg::OP_INSERT) && !hit_q && free_q;
	assign do_clear = finish && (cur_op_q == smes_pkg::OP_REMOVE) && hit_q;

	// Table memory: read one slot per scan cycle, write on insert
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[free_idx_q] <= {cur_row_q, cur_col_q, cur_val_q};
		end
		word_s1  <= mem[addr_q];
		valid_s1 <= valid_q[addr_q];
		idx_s1   <= addr_q;
	end

	// Valid bits: set on insert, drop on remove
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (do_write) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (do_clear) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	// Compare the registered slot with the request
	assign s1_row   = word_s1[WW-1 -: INDEX_BITS];
	assign s1_col   = word_s1[WW-INDEX_BITS-1 -: INDEX_BITS];
	assign s1_match = valid_s1 && (s1_row == cur_row_q) && (s1_col == cur_col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (pop) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (live_s1) begin
			if (s1_match && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!valid_s1 && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	// Record the first match and the lowest free slot
	always_ff @(posedge clk) begin
		if (live_s1 && s1_match && !hit_q) begin
			hit_idx_q <= idx_s1;
			hit_val_q <= word_s1[VALUE_BITS-1:0];
		end
		if (live_s1 && !valid_s1 && !free_q) begin
			free_idx_q <= idx_s1;
		end
	end

	// Build the result
	always_comb begin
		status_d = smes_pkg::ST_OK;
		value_d  = '0;
		case (cur_op_q)
			smes_pkg::OP_INSERT: begin
				if (hit_q) begin
					status_d = smes_pkg::ST_OCCUPIED;
				end else if (!free_q) begin
					status_d = smes_pkg::ST_FULL;
				end
			end
			smes_pkg::OP_REMOVE: begin
				if (!hit_q) begin
					status_d = smes_pkg::ST_ABSENT;
				end
			end
			smes_pkg::OP_READ: begin
				if (hit_q) begin
					value_d = 32'($signed(hit_val_q));
				end else begin
					status_d = smes_pkg::ST_ABSENT;
				end
			end
			smes_pkg::OP_RANGE: status_d = smes_pkg::ST_RANGE;
			default:            status_d = smes_pkg::ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= finish;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			status_q     <= status_d;
			read_value_q <= value_d;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign read_value = read_value_q;

`ifndef SYNTHESIS
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == smes_pkg::ST_FINISH))
		else $error("result strobe without a finished request");
	a_hit_is_live: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && hit_q) |-> valid_q[hit_idx_q])
		else $error("matched slot is not valid");
	a_insert_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |=> valid_q[$past(free_idx_q)])
		else $error("inserted slot not marked valid");
	a_free_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && free_q) |-> !valid_q[free_idx_q])
		else $error("free slot found valid at finish");
`endif

endmodule

FILE: sv/sparse_matrix_entry_store.sv
// Top level of the sparse matrix entry store.
//
// Requests: drive command, row, col and value with start high; the request is
// taken at a rising edge where start is high and busy is low. busy rises only
// when the request queue (two deep) is full.
// Commands: insert, remove and read of a 1-based (row, col) element. Indices
// are checked against row_count and col_count before any table access.
// Results: one per request, in request order, shown on status and read_value
// for exactly one cycle with done high. The receiver cannot stall them.
// Scanning: an insert, remove or read walks the whole table one slot per cycle
// through the single table read port, which sets the throughput; the scanner
// takes one request at a time, while the queue holds up to two more behind it.
// An out-of-range or unused command skips the scan.
// Configuration: write_en, reg_index and write_data write a dimension
// register; write only while no request is outstanding.
// Reset: arst_n clears the table (all slots free), sets both dimensions to 1
// and empties the queue.
module sparse_matrix_entry_store #(
	parameter int ENTRY_COUNT = 64,
	parameter int INDEX_BITS  = 16,
	parameter int VALUE_BITS  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                write_en,
	input  logic [smes_pkg::REG_INDEX_BITS-1:0] reg_index,
	input  logic [INDEX_BITS-1:0]               write_data,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          command,
	input  logic [INDEX_BITS-1:0]               row,
	input  logic [INDEX_BITS-1:0]               col,
	input  logic signed [VALUE_BITS-1:0]        value,
	output logic                                done,
	output logic [2:0]                          status,
	output logic signed [31:0]                  read_value
);

	localparam int OPW = $bits(smes_pkg::op_t);
	localparam int QW  = OPW + 2 * INDEX_BITS + VALUE_BITS;

	smes_pkg::op_t        op;
	logic                 full;
	logic                 push;
	logic                 empty;
	logic [QW-1:0]        pop_data;
	smes_pkg::queue_ctl_t ctl;

	assign busy = full;
	assign push = start && !full;

	// Classify incoming requests
	smes_front #(
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.write_en  (write_en),
		.reg_index (reg_index),
		.write_data(write_data),
		.command   (command),
		.row       (row),
		.col       (col),
		.op        (op)
	);

	// Queue classified requests
	smes_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({op, row, col, value}),
		.full     (full),
		.ctl_in   (ctl),
		.empty    (empty),
		.pop_data (pop_data)
	);

	// Scan the table and answer
	smes_back #(
		.ENTRY_COUNT(ENTRY_COUNT),
		.INDEX_BITS (INDEX_BITS),
		.VALUE_BITS (VALUE_BITS),
		.QW         (QW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop_data  (pop_data),
		.ctl_out   (ctl),
		.done      (done),
		.status    (status),
		.read_value(read_value)
	);

endmodule
